### hdl/atan2ba_pkg.sv
// ----------------------------------------------------------------------------
// atan2ba_pkg
// Shared types and fixed-point constants of the binary-angle arctangent.
// ----------------------------------------------------------------------------
package atan2ba_pkg;

  localparam int ANGLE_W = 32;
  localparam int K4_W    = 27;
  localparam int C_W     = 30;

  // polynomial coefficients, 2^31 = pi
  localparam logic [C_W-1:0]  K3_FIX = 30'd664287388;
  localparam logic [K4_W-1:0] K4_FIX = 27'd130324936;

  // per-beat sideband that rides along the divider
  typedef struct packed {
    logic       neg;   // ratio is negative
    logic [1:0] quad;  // quarter-turn offset
  } side_t;

endpackage

### hdl/atan2_binary_angle.sv
// ----------------------------------------------------------------------------
// atan2_binary_angle
// Four-quadrant arctangent of (y, x) as a 32-bit binary angle, 2^31 = pi.
//
//   channel   ports                      handshake
//   input     y_coord, x_coord           start, busy (accepted: start & !busy)
//   result    angle                      done, one-cycle strobe
//
// One beat per clock; busy is never raised. The pipeline is the octant stage,
// the divider (one quotient bit per stage), three multiply stages, the
// coefficient subtract and the offset add. Reset clears all valid bits; beats
// in flight are dropped.
// The receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module atan2_binary_angle #(
  parameter int INPUT_WIDTH        = 30,
  parameter int QUOTIENT_FRAC_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [INPUT_WIDTH-1:0]          y_coord,
  input  logic signed [INPUT_WIDTH-1:0]          x_coord,
  output logic                                   done,
  output logic signed [atan2ba_pkg::ANGLE_W-1:0] angle
);
  import atan2ba_pkg::*;

  localparam int W  = INPUT_WIDTH;
  localparam int F  = QUOTIENT_FRAC_BITS;
  localparam int MW = F + 1;
  localparam logic [C_W-1:0] C_MIN = K3_FIX - C_W'(K4_FIX);

  // octant select
  logic signed [W:0] ys, xs, u, v, t, b, t_abs;
  logic              uneg, vneg, swap;
  side_t             side_front;

  always_comb begin
    ys    = {y_coord[W-1], y_coord};
    xs    = {x_coord[W-1], x_coord};
    u     = xs + ys;
    v     = xs - ys;
    uneg  = u[W];
    vneg  = v[W];
    swap  = uneg ^ vneg;
    t     = swap ? -xs : ys;
    b     = swap ? ys : xs;
    t_abs = t[W] ? -t : t;
    side_front.neg  = t[W] ^ b[W];
    side_front.quad = {uneg, uneg ^ vneg};
  end

  logic [W:0] b_abs;
  assign b_abs = b[W] ? -b : b;

  logic          v0;
  logic [W-1:0]  tm0, bm0;
  side_t         side0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    tm0   <= t_abs[W-1:0];
    bm0   <= b_abs[W-1:0];
    side0 <= side_front;
  end

  // ratio magnitude, Q1.F
  logic          vd;
  logic [MW-1:0] md;
  side_t         sided;

  atan2ba_div #(
    .WIDTH (W),
    .FRAC  (F)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .num       (tm0),
    .den       (bm0),
    .in_side   (side0),
    .out_valid (vd),
    .quo       (md),
    .out_side  (sided)
  );

  // polynomial: g = m * (K3 - K4 * m^2)
  logic               sq_v, p_v, c_v, g_v;
  logic [MW-1:0]      m1, m2, m3;
  side_t              side1, side2, side3, side4;
  logic [MW-1:0]      sq;
  logic [K4_W-1:0]    p;
  logic [C_W-1:0]     c;
  logic [C_W-1:0]     g;

  logic [2*MW-1:0]    sq_prod;
  logic [K4_W+MW-1:0] p_prod;
  logic [C_W+MW-1:0]  g_prod;

  assign sq_prod = (2*MW)'(md) * (2*MW)'(md);
  assign p_prod  = (K4_W+MW)'(K4_FIX) * (K4_W+MW)'(sq);
  assign g_prod  = (C_W+MW)'(m3) * (C_W+MW)'(c);

  logic [ANGLE_W-1:0] g_ext, g_signed, angle_next;

  always_comb begin
    g_ext      = ANGLE_W'(g);
    g_signed   = side4.neg ? -g_ext : g_ext;
    angle_next = {side4.quad, {(ANGLE_W-2){1'b0}}} + g_signed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
      p_v  <= 1'b0;
      c_v  <= 1'b0;
      g_v  <= 1'b0;
      done <= 1'b0;
    end else begin
      sq_v <= vd;
      p_v  <= sq_v;
      c_v  <= p_v;
      g_v  <= c_v;
      done <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    sq    <= sq_prod[2*F:F];
    m1    <= md;
    side1 <= sided;
    p     <= p_prod[F+K4_W-1:F];
    m2    <= m1;
    side2 <= side1;
    c     <= K3_FIX - C_W'(p);
    m3    <= m2;
    side3 <= side2;
    g     <= g_prod[F+C_W-1:F];
    side4 <= side3;
    angle <= angle_next;
  end

  assign busy = 1'b0;

  a_num_le_den: assert property (@(posedge clk) disable iff (rst)
    v0 |-> (tm0 <= bm0))
    else $error("ratio magnitude above one");

  a_coef_range: assert property (@(posedge clk) disable iff (rst)
    c_v |-> ((c >= C_MIN) && (c <= K3_FIX)))
    else $error("coefficient out of range");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(g_v))
    else $error("result strobe without a beat in the last stage");

endmodule

### hdl/atan2ba_div.sv
// ----------------------------------------------------------------------------
// atan2ba_div
// Pipelined restoring divider, one quotient bit per stage: quo = num*2^FRAC/den
// for num <= den. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module atan2ba_div #(
  parameter int WIDTH = 30,
  parameter int FRAC  = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [WIDTH-1:0]    num,
  input  logic [WIDTH-1:0]    den,
  input  atan2ba_pkg::side_t  in_side,
  output logic                out_valid,
  output logic [FRAC:0]       quo,
  output atan2ba_pkg::side_t  out_side
);
  import atan2ba_pkg::*;

  localparam int STAGES = FRAC + 1;

  logic [STAGES-1:0] v_q;
  logic [WIDTH:0]    rem_q  [0:STAGES-2];
  logic [WIDTH-1:0]  den_q  [0:STAGES-2];
  logic [FRAC:0]     quo_q  [0:STAGES-1];
  side_t             side_q [0:STAGES-1];
  logic              zero_q [0:STAGES-1];

  logic [WIDTH:0]    r_in   [0:STAGES-1];
  logic [WIDTH-1:0]  d_in   [0:STAGES-1];
  logic [FRAC:0]     q_in   [0:STAGES-1];
  side_t             s_in   [0:STAGES-1];
  logic              z_in   [0:STAGES-1];
  logic [STAGES-1:0] vld_in;
  logic [STAGES-1:0] ge;
  logic [WIDTH:0]    diff   [0:STAGES-1];

  always_comb begin
    r_in[0]   = {1'b0, num};
    d_in[0]   = den;
    q_in[0]   = '0;
    s_in[0]   = in_side;
    z_in[0]   = (den == '0);
    vld_in[0] = in_valid;
    for (int s = 1; s < STAGES; s++) begin
      r_in[s]   = rem_q[s-1];
      d_in[s]   = den_q[s-1];
      q_in[s]   = quo_q[s-1];
      s_in[s]   = side_q[s-1];
      z_in[s]   = zero_q[s-1];
      vld_in[s] = v_q[s-1];
    end
    for (int s = 0; s < STAGES; s++) begin
      ge[s]   = (r_in[s] >= {1'b0, d_in[s]});
      diff[s] = r_in[s] - {1'b0, d_in[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else begin
      v_q <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      quo_q[s]  <= {q_in[s][FRAC-1:0], ge[s]};
      side_q[s] <= s_in[s];
      zero_q[s] <= z_in[s];
    end
    // partial remainder stays below 2*den
    for (int s = 0; s < STAGES - 1; s++) begin
      rem_q[s] <= ge[s] ? {diff[s][WIDTH-1:0], 1'b0} : {r_in[s][WIDTH-1:0], 1'b0};
      den_q[s] <= d_in[s];
    end
  end

  assign out_valid = v_q[STAGES-1];
  assign quo       = zero_q[STAGES-1] ? '0 : quo_q[STAGES-1];
  assign out_side  = side_q[STAGES-1];

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (v_q[0] && !zero_q[0]) |-> (rem_q[0] < {den_q[0], 1'b0}))
    else $error("divider remainder out of range");

  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (quo <= ((FRAC+1)'(1) << FRAC)))
    else $error("quotient above one");

endmodule
